[hw/rtl/graph_bfs_bipartite_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the graph search engine
// Shared implication forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_BIPARTITE_ENGINE_UNIT_MACROS_SVH
`define GRAPH_BFS_BIPARTITE_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBFS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbfs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GBFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbfs assertion failed");

`endif

[hw/rtl/gbfs_pkg.sv]
// ----------------------------------------------------------------------------
// gbfs_pkg
// Widths, opcodes and special codes of the graph search engine.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int NBR_AW       = 2 * VTX_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Distance or predecessor of a vertex not reached (minus one).
  localparam logic [CNT_W-1:0] DIST_NONE = 7'h7F;
  localparam logic [1:0]       UNCOLOURED = 2'd2;
  localparam logic [CNT_W-1:0] VC_MAX     = 7'd64;

endpackage

[hw/rtl/graph_bfs_bipartite_engine_unit.sv]
// The engine takes one item at a time: it accepts a new item only in the idle state. A
// search or check spends most of its time on the list entries, each one a neighbour read,
// then a distance or colour read, then the update.
// Reset (synchronous, rst_n low): vertex count 64, all neighbour lists empty,
// output channel empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// graph_bfs_bipartite_engine_unit
// Undirected graph store with breadth-first search and a two-colouring test,
// run by a small sequencer over memories with one write and one read port each.
// ----------------------------------------------------------------------------
module graph_bfs_bipartite_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: vertex_count.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] vertex_a, [11:6] vertex_b, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] vertex_index, [12:6] distance,
                                  // [19:13] predecessor, [20] is_bipartite, rest zero
  output logic        out_tuser,  // [0] status
  output logic        out_tlast   // last result of the item
);

  localparam int VW = gbfs_pkg::VTX_W;
  localparam int CW = gbfs_pkg::CNT_W;
  localparam int NV = gbfs_pkg::MAX_VERTICES;

  // Sequencer states. The traversal states are shared by the search and
  // the check; the latched opcode decides what a visited neighbour does.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DISP   = 5'd1;
  localparam logic [4:0] ST_I_DA   = 5'd2;
  localparam logic [4:0] ST_I_SCAN = 5'd3;
  localparam logic [4:0] ST_I_CMP  = 5'd4;
  localparam logic [4:0] ST_I_ADDA = 5'd5;
  localparam logic [4:0] ST_I_DB   = 5'd6;
  localparam logic [4:0] ST_I_ADDB = 5'd7;
  localparam logic [4:0] ST_INIT   = 5'd8;
  localparam logic [4:0] ST_B_ORG  = 5'd9;
  localparam logic [4:0] ST_T_POP  = 5'd10;
  localparam logic [4:0] ST_T_U    = 5'd11;
  localparam logic [4:0] ST_T_DEG  = 5'd12;
  localparam logic [4:0] ST_T_NB   = 5'd13;
  localparam logic [4:0] ST_T_V    = 5'd14;
  localparam logic [4:0] ST_T_CHK  = 5'd15;
  localparam logic [4:0] ST_B_OUT  = 5'd16;
  localparam logic [4:0] ST_B_OUTW = 5'd17;
  localparam logic [4:0] ST_C_S    = 5'd18;
  localparam logic [4:0] ST_C_SC   = 5'd19;
  localparam logic [4:0] ST_EMIT   = 5'd20;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] vc_r;
  logic [1:0]    op_r, op_nxt;
  logic [VW-1:0] a_r, a_nxt, b_r, b_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [CW-1:0] deg_r, deg_nxt, j_r, j_nxt, i_r, i_nxt, du_r, du_nxt;
  logic          cu_r, cu_nxt, bip_r, bip_nxt;
  logic [VW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  // Neighbour lists: row = vertex, column = list position.
  logic [VW-1:0]     nbr_mem [1 << gbfs_pkg::NBR_AW];
  logic              nbr_we;
  logic [gbfs_pkg::NBR_AW-1:0] nbr_waddr, nbr_raddr;
  logic [VW-1:0]     nbr_wdata, nbr_rd_r;

  // Degree memory; an entry without its valid bit reads as zero.
  logic [CW-1:0]     deg_mem [NV];
  logic [NV-1:0]     deg_vld_r;
  logic              deg_we, deg_clr, deg_rv_r;
  logic [VW-1:0]     deg_waddr, deg_raddr;
  logic [CW-1:0]     deg_wdata, deg_rd_r, deg_q;

  // Per-vertex search state and the vertex queue.
  logic [CW-1:0]     dist_mem [NV];
  logic [CW-1:0]     pred_mem [NV];
  logic [1:0]        col_mem  [NV];
  logic [VW-1:0]     q_mem    [NV];
  logic              dist_we, pred_we, col_we, q_we;
  logic [VW-1:0]     st_waddr, dist_raddr, col_raddr, q_raddr;
  logic [CW-1:0]     dist_wdata, pred_wdata, dist_rd_r, pred_rd_r;
  logic [1:0]        col_wdata, col_rd_r;
  logic [VW-1:0]     q_wdata, q_rd_r;

  // Output register.
  logic              out_valid_r, out_load, out_free;
  logic [VW-1:0]     o_vi_r, o_vi_nxt;
  logic [CW-1:0]     o_dist_r, o_dist_nxt, o_pred_r, o_pred_nxt;
  logic              o_bip_r, o_bip_nxt, o_st_r, o_st_nxt, o_last_r, o_last_nxt;

  logic              in_acc;
  logic [CW-1:0]     vc_last, jm1;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign deg_q     = deg_rv_r ? deg_rd_r : '0;
  assign vc_last   = vc_r - 7'd1;
  assign jm1       = j_r - 7'd1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_bip_r, o_pred_r, o_dist_r, o_vi_r};
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;  a_nxt = a_r;  b_nxt = b_r;  u_nxt = u_r;  v_nxt = v_r;
    deg_nxt = deg_r;  j_nxt = j_r;  i_nxt = i_r;  du_nxt = du_r;
    cu_nxt = cu_r;  bip_nxt = bip_r;
    head_nxt = head_r;  tail_nxt = tail_r;  fill_nxt = fill_r;
    nbr_we = 1'b0;  nbr_waddr = '0;  nbr_wdata = '0;  nbr_raddr = '0;
    deg_we = 1'b0;  deg_clr = 1'b0;  deg_waddr = '0;  deg_wdata = '0;  deg_raddr = '0;
    dist_we = 1'b0;  pred_we = 1'b0;  col_we = 1'b0;  q_we = 1'b0;
    st_waddr = '0;  dist_wdata = '0;  pred_wdata = '0;  col_wdata = '0;
    q_wdata = '0;  dist_raddr = '0;  col_raddr = '0;  q_raddr = '0;
    out_load = 1'b0;
    o_vi_nxt = '0;  o_dist_nxt = '0;  o_pred_nxt = '0;
    o_bip_nxt = 1'b0;  o_st_nxt = 1'b0;  o_last_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          a_nxt     = in_tdata[5:0];
          b_nxt     = in_tdata[11:6];
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        case (op_r)
          gbfs_pkg::OP_INSERT: begin
            if ({1'b0, a_r} >= vc_r || {1'b0, b_r} >= vc_r || a_r == b_r) begin
              state_nxt = ST_IDLE;
            end else begin
              deg_raddr = a_r;
              state_nxt = ST_I_DA;
            end
          end
          gbfs_pkg::OP_SEARCH: begin
            i_nxt     = '0;
            state_nxt = ({1'b0, a_r} >= vc_r) ? ST_EMIT : ST_INIT;
          end
          gbfs_pkg::OP_CHECK: begin
            i_nxt     = '0;
            state_nxt = ST_INIT;
          end
          default: begin
            deg_clr   = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_I_DA: begin
        deg_nxt   = deg_q;
        j_nxt     = '0;
        state_nxt = ST_I_SCAN;
      end
      ST_I_SCAN: begin
        if (j_r >= deg_r) begin
          state_nxt = ST_I_ADDA;
        end else begin
          nbr_raddr = {a_r, j_r[VW-1:0]};
          state_nxt = ST_I_CMP;
        end
      end
      ST_I_CMP: begin
        if (nbr_rd_r == b_r) begin
          state_nxt = ST_IDLE;
        end else begin
          j_nxt     = j_r + 7'd1;
          state_nxt = ST_I_SCAN;
        end
      end
      ST_I_ADDA: begin
        if (deg_r < gbfs_pkg::VC_MAX) begin
          nbr_we    = 1'b1;
          nbr_waddr = {a_r, deg_r[VW-1:0]};
          nbr_wdata = b_r;
          deg_we    = 1'b1;
          deg_waddr = a_r;
          deg_wdata = deg_r + 7'd1;
        end
        deg_raddr = b_r;
        state_nxt = ST_I_DB;
      end
      ST_I_DB: begin
        deg_nxt   = deg_q;
        state_nxt = ST_I_ADDB;
      end
      ST_I_ADDB: begin
        if (deg_r < gbfs_pkg::VC_MAX) begin
          nbr_we    = 1'b1;
          nbr_waddr = {b_r, deg_r[VW-1:0]};
          nbr_wdata = a_r;
          deg_we    = 1'b1;
          deg_waddr = b_r;
          deg_wdata = deg_r + 7'd1;
        end
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        dist_we    = 1'b1;
        pred_we    = 1'b1;
        col_we     = 1'b1;
        st_waddr   = i_r[VW-1:0];
        dist_wdata = gbfs_pkg::DIST_NONE;
        pred_wdata = gbfs_pkg::DIST_NONE;
        col_wdata  = gbfs_pkg::UNCOLOURED;
        head_nxt   = '0;
        tail_nxt   = '0;
        fill_nxt   = '0;
        if (i_r == vc_last) begin
          i_nxt     = '0;
          state_nxt = (op_r == gbfs_pkg::OP_SEARCH) ? ST_B_ORG : ST_C_S;
        end else begin
          i_nxt = i_r + 7'd1;
        end
      end
      ST_B_ORG: begin
        dist_we    = 1'b1;
        st_waddr   = a_r;
        dist_wdata = '0;
        q_we       = 1'b1;
        q_wdata    = a_r;
        tail_nxt   = tail_r + 6'd1;
        fill_nxt   = fill_r + 7'd1;
        state_nxt  = ST_T_POP;
      end
      ST_T_POP: begin
        if (fill_r == '0) begin
          if (op_r == gbfs_pkg::OP_SEARCH) begin
            i_nxt     = '0;
            state_nxt = ST_B_OUT;
          end else begin
            i_nxt     = i_r + 7'd1;
            state_nxt = ST_C_S;
          end
        end else begin
          q_raddr   = head_r;
          head_nxt  = head_r + 6'd1;
          fill_nxt  = fill_r - 7'd1;
          state_nxt = ST_T_U;
        end
      end
      ST_T_U: begin
        u_nxt      = q_rd_r;
        deg_raddr  = q_rd_r;
        dist_raddr = q_rd_r;
        col_raddr  = q_rd_r;
        state_nxt  = ST_T_DEG;
      end
      ST_T_DEG: begin
        j_nxt     = deg_q;
        du_nxt    = dist_rd_r;
        cu_nxt    = col_rd_r[0];
        state_nxt = ST_T_NB;
      end
      ST_T_NB: begin
        if (j_r == '0) begin
          state_nxt = ST_T_POP;
        end else begin
          j_nxt     = jm1;
          nbr_raddr = {u_r, jm1[VW-1:0]};
          state_nxt = ST_T_V;
        end
      end
      ST_T_V: begin
        v_nxt = nbr_rd_r;
        if ({1'b0, nbr_rd_r} >= vc_r) begin
          state_nxt = ST_T_NB;
        end else begin
          dist_raddr = nbr_rd_r;
          col_raddr  = nbr_rd_r;
          state_nxt  = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        state_nxt = ST_T_NB;
        st_waddr  = v_r;
        q_wdata   = v_r;
        if (op_r == gbfs_pkg::OP_SEARCH) begin
          if (dist_rd_r == gbfs_pkg::DIST_NONE) begin
            dist_we    = 1'b1;
            pred_we    = 1'b1;
            dist_wdata = du_r + 7'd1;
            pred_wdata = {1'b0, u_r};
            q_we       = 1'b1;
            tail_nxt   = tail_r + 6'd1;
            fill_nxt   = fill_r + 7'd1;
          end
        end else begin
          if (col_rd_r == gbfs_pkg::UNCOLOURED) begin
            col_we    = 1'b1;
            col_wdata = {1'b0, ~cu_r};
            q_we      = 1'b1;
            tail_nxt  = tail_r + 6'd1;
            fill_nxt  = fill_r + 7'd1;
          end else if (col_rd_r[0] == cu_r) begin
            bip_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_B_OUT: begin
        dist_raddr = i_r[VW-1:0];
        state_nxt  = ST_B_OUTW;
      end
      ST_B_OUTW: begin
        dist_raddr = i_r[VW-1:0];
        if (out_free) begin
          out_load   = 1'b1;
          o_vi_nxt   = i_r[VW-1:0];
          o_dist_nxt = dist_rd_r;
          o_pred_nxt = pred_rd_r;
          o_last_nxt = (i_r == vc_last);
          if (i_r == vc_last) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 7'd1;
            state_nxt = ST_B_OUT;
          end
        end
      end
      ST_C_S: begin
        if (i_r == vc_r) begin
          bip_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          col_raddr = i_r[VW-1:0];
          state_nxt = ST_C_SC;
        end
      end
      ST_C_SC: begin
        if (col_rd_r != gbfs_pkg::UNCOLOURED) begin
          i_nxt     = i_r + 7'd1;
          state_nxt = ST_C_S;
        end else begin
          col_we    = 1'b1;
          st_waddr  = i_r[VW-1:0];
          col_wdata = '0;
          q_we      = 1'b1;
          q_wdata   = i_r[VW-1:0];
          tail_nxt  = tail_r + 6'd1;
          fill_nxt  = fill_r + 7'd1;
          state_nxt = ST_T_POP;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_last_nxt = 1'b1;
          if (op_r == gbfs_pkg::OP_SEARCH) begin
            o_dist_nxt = gbfs_pkg::DIST_NONE;
            o_pred_nxt = gbfs_pkg::DIST_NONE;
            o_st_nxt   = 1'b1;
          end else begin
            o_bip_nxt = bip_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= gbfs_pkg::VC_MAX;
      deg_vld_r   <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      if (cfg_valid) begin
        if (cfg_data == '0) begin
          vc_r <= 7'd1;
        end else if (cfg_data > gbfs_pkg::VC_MAX) begin
          vc_r <= gbfs_pkg::VC_MAX;
        end else begin
          vc_r <= cfg_data;
        end
      end
      if (deg_clr) begin
        deg_vld_r <= '0;
      end else if (deg_we) begin
        deg_vld_r[deg_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  u_r <= u_nxt;  v_r <= v_nxt;
    deg_r <= deg_nxt;  j_r <= j_nxt;  i_r <= i_nxt;  du_r <= du_nxt;
    cu_r <= cu_nxt;  bip_r <= bip_nxt;
    if (out_load) begin
      o_vi_r   <= o_vi_nxt;
      o_dist_r <= o_dist_nxt;
      o_pred_r <= o_pred_nxt;
      o_bip_r  <= o_bip_nxt;
      o_st_r   <= o_st_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= nbr_wdata;
    end
    nbr_rd_r <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_r <= deg_mem[deg_raddr];
    deg_rv_r <= deg_vld_r[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[st_waddr] <= dist_wdata;
    end
    dist_rd_r <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[st_waddr] <= pred_wdata;
    end
    pred_rd_r <= pred_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[st_waddr] <= col_wdata;
    end
    col_rd_r <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r] <= q_wdata;
    end
    q_rd_r <= q_mem[q_raddr];
  end

endmodule

[hw/rtl/gbfs_checker.sv]
// ----------------------------------------------------------------------------
// gbfs_checker
// Port-level checks on the graph search engine, bound to its top level.
// ----------------------------------------------------------------------------
`include "graph_bfs_bipartite_engine_unit_macros.svh"

module gbfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A held result keeps its payload.
  `GBFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // An origin error is always the one and only result of its item.
  `GBFS_ASSERT_SAME(a_err_last, out_tvalid && out_tuser, out_tlast)
  // An origin error reports no distance and no predecessor.
  `GBFS_ASSERT_SAME(a_err_none, out_tvalid && out_tuser, (out_tdata[12:6] == gbfs_pkg::DIST_NONE) && (out_tdata[19:13] == gbfs_pkg::DIST_NONE))
  // Every item leaves the idle state on acceptance, so the block is busy after a beat.
  `GBFS_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)

endmodule

bind graph_bfs_bipartite_engine_unit gbfs_checker u_gbfs_checker (.*);

[bench/graph_bfs_bipartite_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// graph_bfs_bipartite_engine_unit_tb
// Drives edge inserts, searches, bipartite checks and clears with random gaps
// on both streams, predicts every result beat in the bench and checks each one.
// ----------------------------------------------------------------------------
module graph_bfs_bipartite_engine_unit_tb;

  typedef struct packed {
    logic [5:0] vidx;
    logic [6:0] hops;
    logic [6:0] pred;
    logic       bip;
    logic       status;
    logic       last;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Bench copy of the graph and the vertex count.
  int    vcount;
  int    adj[64][64];
  int    deg[64];
  beat_t expected_beats[$];
  int    failures;
  int    beats_seen;
  int    items_sent;

  graph_bfs_bipartite_engine_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("graph_bfs_bipartite_engine_unit_tb failed");
    $finish;
  end

  // Breadth-first search over the bench graph; neighbours newest first.
  task automatic predict_search(input int origin);
    int hop[64];
    int pred[64];
    int fifo[$];
    int u;
    int v;
    beat_t b;
    if (origin >= vcount) begin
      b = '{vidx: 6'd0, hops: gbfs_pkg::DIST_NONE, pred: gbfs_pkg::DIST_NONE, bip: 1'b0,
            status: 1'b1, last: 1'b1};
      expected_beats.push_back(b);
      return;
    end
    for (int i = 0; i < 64; i++) begin
      hop[i]  = -1;
      pred[i] = -1;
    end
    hop[origin] = 0;
    fifo.push_back(origin);
    while (fifo.size() > 0) begin
      u = fifo.pop_front();
      for (int j = deg[u] - 1; j >= 0; j--) begin
        v = adj[u][j];
        if (v < vcount && hop[v] == -1) begin
          hop[v]  = hop[u] + 1;
          pred[v] = u;
          fifo.push_back(v);
        end
      end
    end
    for (int i = 0; i < vcount; i++) begin
      b = '{vidx: i[5:0], hops: hop[i][6:0], pred: pred[i][6:0], bip: 1'b0,
            status: 1'b0, last: (i == vcount - 1)};
      expected_beats.push_back(b);
    end
  endtask

  // Two-colouring over every component; stops at the first clash.
  function automatic logic two_colourable();
    int colour[64];
    int fifo[$];
    int u;
    int v;
    for (int i = 0; i < 64; i++) colour[i] = gbfs_pkg::UNCOLOURED;
    for (int s = 0; s < vcount; s++) begin
      if (colour[s] != gbfs_pkg::UNCOLOURED) continue;
      colour[s] = 0;
      fifo.push_back(s);
      while (fifo.size() > 0) begin
        u = fifo.pop_front();
        for (int j = deg[u] - 1; j >= 0; j--) begin
          v = adj[u][j];
          if (v >= vcount) continue;
          if (colour[v] == gbfs_pkg::UNCOLOURED) begin
            colour[v] = 1 - colour[u];
            fifo.push_back(v);
          end else if (colour[v] == colour[u]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic update_graph(input logic [1:0] op, input int a, input int bv);
    beat_t r;
    bit dup;
    case (op)
      gbfs_pkg::OP_INSERT: begin
        if (a < vcount && bv < vcount && a != bv) begin
          dup = 0;
          for (int i = 0; i < deg[a]; i++) if (adj[a][i] == bv) dup = 1;
          if (!dup) begin
            adj[a][deg[a]] = bv;
            deg[a]++;
            adj[bv][deg[bv]] = a;
            deg[bv]++;
          end
        end
      end
      gbfs_pkg::OP_SEARCH: predict_search(a);
      gbfs_pkg::OP_CHECK: begin
        r = '{vidx: 6'd0, hops: 7'd0, pred: 7'd0, bip: two_colourable(), status: 1'b0,
              last: 1'b1};
        expected_beats.push_back(r);
      end
      default: for (int i = 0; i < 64; i++) deg[i] = 0;
    endcase
  endtask

  // Sends one item after a random gap and updates the prediction on acceptance.
  // The valid stays up after the beat until the next gap or a drain takes it down.
  task automatic send_item(input logic [1:0] op, input logic [5:0] a, input logic [5:0] bv);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, bv, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_graph(op, a, bv);
    items_sent++;
  endtask

  // Waits until the predicted results have all arrived, then lets the engine settle
  // so that a trailing insert or clear has finished too.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    int v;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    v = value;
    if (v < 1) v = 1;
    if (v > gbfs_pkg::MAX_VERTICES) v = gbfs_pkg::MAX_VERTICES;
    vcount = v;
  endtask

  // Result stall: a fresh random wait for every beat, sometimes none.
  initial begin
    out_tready = 1'b0;
    forever begin
      int stall;
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Compares every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        failures++;
      end else begin
        e = expected_beats.pop_front();
        if (out_tdata[5:0] !== e.vidx) begin
          $error("vertex_index expected %0d got %0d", e.vidx, out_tdata[5:0]);
          failures++;
        end
        if (out_tdata[12:6] !== e.hops) begin
          $error("distance expected %0d got %0d", $signed(e.hops),
                 $signed(out_tdata[12:6]));
          failures++;
        end
        if (out_tdata[19:13] !== e.pred) begin
          $error("predecessor expected %0d got %0d", $signed(e.pred),
                 $signed(out_tdata[19:13]));
          failures++;
        end
        if (out_tdata[20] !== e.bip) begin
          $error("is_bipartite expected %0b got %0b", e.bip, out_tdata[20]);
          failures++;
        end
        if (out_tuser !== e.status) begin
          $error("status expected %0b got %0b", e.status, out_tuser);
          failures++;
        end
        if (out_tlast !== e.last) begin
          $error("last expected %0b got %0b", e.last, out_tlast);
          failures++;
        end
      end
    end
  end

  // Extremes: full size, bad origins, self-loops, duplicates, top vertex 63.
  task automatic test_directed();
    send_item(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0);
    send_item(gbfs_pkg::OP_CHECK, 6'd63, 6'd63);
    send_item(gbfs_pkg::OP_INSERT, 6'd0, 6'd63);
    send_item(gbfs_pkg::OP_INSERT, 6'd63, 6'd0);
    send_item(gbfs_pkg::OP_INSERT, 6'd5, 6'd5);
    send_item(gbfs_pkg::OP_INSERT, 6'd63, 6'd42);
    send_item(gbfs_pkg::OP_INSERT, 6'd0, 6'd42);
    send_item(gbfs_pkg::OP_SEARCH, 6'd63, 6'd21);
    send_item(gbfs_pkg::OP_CHECK, 6'd0, 6'd0);
    send_item(gbfs_pkg::OP_CLEAR, 6'd63, 6'd63);
    send_item(gbfs_pkg::OP_CHECK, 6'd0, 6'd0);
    write_vertex_count(7'd0);
    send_item(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0);
    send_item(gbfs_pkg::OP_SEARCH, 6'd1, 6'd0);
    send_item(gbfs_pkg::OP_INSERT, 6'd0, 6'd1);
    write_vertex_count(7'd127);
    send_item(gbfs_pkg::OP_INSERT, 6'd1, 6'd2);
    send_item(gbfs_pkg::OP_INSERT, 6'd2, 6'd3);
    write_vertex_count(7'd3);
    send_item(gbfs_pkg::OP_INSERT, 6'd2, 6'd3);
    send_item(gbfs_pkg::OP_SEARCH, 6'd3, 6'd0);
    send_item(gbfs_pkg::OP_SEARCH, 6'd2, 6'd0);
    send_item(gbfs_pkg::OP_CHECK, 6'd0, 6'd0);
    send_item(gbfs_pkg::OP_CLEAR, 6'd0, 6'd0);
  endtask

  // Small graphs built from random edges with searches and checks mixed in;
  // the sender also waits for the engine to drain at random points.
  task automatic test_random(input int count);
    int sel;
    int vmax;
    logic [5:0] a;
    logic [5:0] bv;
    for (int n = 0; n < count; n++) begin
      vmax = (vcount > 1) ? vcount - 1 : 1;
      sel  = $urandom_range(0, 99);
      a    = (sel % 10 == 0) ? 6'($urandom) : 6'($urandom_range(0, vmax));
      bv   = (sel % 7 == 0) ? 6'($urandom) : 6'($urandom_range(0, vmax));
      if (sel < 60)      send_item(gbfs_pkg::OP_INSERT, a, bv);
      else if (sel < 80) send_item(gbfs_pkg::OP_SEARCH, a, bv);
      else if (sel < 95) send_item(gbfs_pkg::OP_CHECK, a, bv);
      else               send_item(gbfs_pkg::OP_CLEAR, a, bv);
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 7'd0;
    in_tvalid = 1'b0;
    in_tdata  = 16'd0;
    in_tuser  = gbfs_pkg::OP_INSERT;
    vcount    = gbfs_pkg::MAX_VERTICES;
    failures  = 0;
    beats_seen = 0;
    items_sent = 0;
    for (int i = 0; i < 64; i++) deg[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_vertex_count(7'd8);
    test_random(35);
    write_vertex_count(7'd20);
    test_random(35);
    write_vertex_count(7'd64);
    test_random(35);
    write_vertex_count(7'd2);
    test_random(15);

    drain();
    $display("Sent %0d items over vertex counts 1, 2, 3, 8, 20 and 64;", items_sent);
    $display("checked %0d result beats of searches and bipartite checks.", beats_seen);
    if (failures == 0) begin
      $display("graph_bfs_bipartite_engine_unit_tb passed");
    end else begin
      $display("graph_bfs_bipartite_engine_unit_tb failed");
    end
    $finish;
  end

endmodule
